FILE: src/base64_stream_encoder_macros.svh
// Assertion macros used by the base64 stream encoder back end.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64E_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("base64 encoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define B64E_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("base64 encoder assertion failed");

`endif

FILE: src/b64e_pkg.sv
// Shared types, constants and the alphabet function of the base64 stream encoder.
// Depends on nothing; used by the encoder modules and the testbench.
package b64e_pkg;

  localparam logic [6:0] PadChar = 7'h3D;
  localparam logic [1:0] LastIdx = 2'd3;

  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // One closed group of one to three bytes; missing bytes are zero.
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [1:0] nbytes;
    logic       last;
  } grp_t;

  function automatic logic [6:0] b64_sym(input logic [5:0] v);
    logic [6:0] ch;
    if (v < 6'd26) begin
      ch = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      ch = 7'h47 + {1'b0, v};
    end else if (v < 6'd62) begin
      ch = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      ch = 7'h2B;
    end else begin
      ch = 7'h2F;
    end
    return ch;
  endfunction

endpackage

FILE: src/b64e_byte_if.sv
// Input channel of the base64 stream encoder: one message byte per request.
// Depends on nothing.
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

FILE: src/b64e_char_if.sv
// Output channel of the base64 stream encoder: one character per request.
// Depends on nothing.
interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink (input valid, input out_char, input out_last, output ready);
endinterface

FILE: src/base64_stream_encoder.sv
// Top level of the base64 stream encoder: front end, group queue and back end.
// Depends on b64e_pkg, b64e_byte_if, b64e_char_if and the three submodules.
//
// Standard base64 encoder for a byte stream. Each input request carries one byte and
// an end-of-message flag; every third byte, or any flagged byte, closes a group that
// produces four output requests of one ASCII character each, with '=' padding for a
// short final group and out_last set on the fourth character of the flagged group.
// A byte is taken in every cycle while the two-entry group queue has room, so bursts
// enter at one byte per cycle. The back end sends one character per cycle through its
// output register while the output is ready, so the single-character output port sets
// the sustained rate of four characters per three bytes. When the back end is idle, a
// group's closing byte passes through the queue entry, the back end's group register
// and the output register before the group's first character is offered at the output.
module base64_stream_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64e_byte_if.sink   in_i,
  b64e_char_if.source out_o
);
  import b64e_pkg::*;

  logic grp_in_valid;
  logic grp_in_ready;
  grp_t grp_in;
  logic grp_out_valid;
  logic grp_out_ready;
  grp_t grp_out;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .grp_valid_o (grp_in_valid),
    .grp_ready_i (grp_in_ready),
    .grp_o       (grp_in)
  );

  b64e_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (grp_in_valid),
    .push_ready_o (grp_in_ready),
    .push_grp_i   (grp_in),
    .pop_valid_o  (grp_out_valid),
    .pop_ready_i  (grp_out_ready),
    .pop_grp_o    (grp_out)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (grp_out_valid),
    .grp_ready_o (grp_out_ready),
    .grp_i       (grp_out),
    .out_o       (out_o)
  );
endmodule

FILE: src/b64e_front.sv
// Front end: accepts bytes, holds the open group and closes it into a group record.
// Depends on b64e_pkg and b64e_byte_if.
module b64e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  b64e_byte_if.sink         in_i,
  output logic              grp_valid_o,
  input  logic              grp_ready_i,
  output b64e_pkg::grp_t    grp_o
);
  import b64e_pkg::*;

  logic [7:0] pend0_q, pend0_d;
  logic [7:0] pend1_q, pend1_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] held;
  logic       store;
  logic       accept;

  assign held   = (cnt_q == 2'd3) ? 2'd2 : cnt_q;
  assign store  = !in_i.end_of_message && (held < 2'd2);
  assign accept = in_i.valid && in_i.ready;

  // A request is only taken while the queue has room for a closed group.
  assign in_i.ready  = grp_ready_i;
  assign grp_valid_o = in_i.valid && !store;

  always_comb begin
    grp_o.a      = (held >= 2'd1) ? pend0_q : in_i.data_byte;
    grp_o.b      = (held >= 2'd2) ? pend1_q : ((held == 2'd1) ? in_i.data_byte : 8'h00);
    grp_o.c      = (held == 2'd2) ? in_i.data_byte : 8'h00;
    grp_o.nbytes = held + 2'd1;
    grp_o.last   = in_i.end_of_message;
  end

  always_comb begin
    pend0_d = pend0_q;
    pend1_d = pend1_q;
    cnt_d   = cnt_q;
    if (accept) begin
      if (store) begin
        if (held == 2'd0) begin
          pend0_d = in_i.data_byte;
        end else begin
          pend1_d = in_i.data_byte;
        end
        cnt_d = held + 2'd1;
      end else begin
        cnt_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend0_q <= pend0_d;
    pend1_q <= pend1_d;
  end
endmodule

FILE: src/b64e_queue.sv
// Short queue of closed groups between the front and back ends.
// Depends on b64e_pkg.
module b64e_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  b64e_pkg::grp_t push_grp_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output b64e_pkg::grp_t pop_grp_o
);
  import b64e_pkg::*;

  grp_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_grp_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_grp_i;
    end
  end
endmodule

FILE: src/b64e_back.sv
// Back end: turns each group record into four characters through an output register.
// Depends on b64e_pkg, b64e_char_if and the assertion macro header.
`include "base64_stream_encoder_macros.svh"

module b64e_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           grp_valid_i,
  output logic           grp_ready_o,
  input  b64e_pkg::grp_t grp_i,
  b64e_char_if.source    out_o
);
  import b64e_pkg::*;

  grp_t       grp_q, grp_d;
  logic       busy_q, busy_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [6:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;
  logic       load;
  logic       pop;
  logic [5:0] sym_idx;
  logic       pad;

  assign load        = busy_q && (!out_valid_q || out_o.ready);
  assign grp_ready_o = !busy_q || (load && (idx_q == LastIdx));
  assign pop         = grp_valid_i && grp_ready_o;

  always_comb begin
    case (idx_q)
      2'd0:    sym_idx = grp_q.a[7:2];
      2'd1:    sym_idx = {grp_q.a[1:0], grp_q.b[7:4]};
      2'd2:    sym_idx = {grp_q.b[3:0], grp_q.c[7:6]};
      default: sym_idx = grp_q.c[5:0];
    endcase
  end

  // Short groups replace their trailing symbols with padding.
  assign pad = ((idx_q == LastIdx) && (grp_q.nbytes < 2'd3)) ||
               ((idx_q == 2'd2) && (grp_q.nbytes < 2'd2));

  always_comb begin
    grp_d       = grp_q;
    busy_d      = busy_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      out_char_d  = pad ? PadChar : b64_sym(sym_idx);
      out_last_d  = grp_q.last && (idx_q == LastIdx);
      idx_d       = idx_q + 2'd1;
      if (idx_q == LastIdx) begin
        busy_d = 1'b0;
      end
    end
    if (pop) begin
      grp_d  = grp_i;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q      <= grp_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_char = out_char_q;
  assign out_o.out_last = out_last_q;

  `B64E_ASSERT_IMPL(a_idle_idx_zero, clk_i, rst_ni, !busy_q, idx_q == 2'd0)
  `B64E_ASSERT_NEXT(a_last_on_fourth, clk_i, rst_ni, load && (idx_q != LastIdx), !out_last_q)
  `B64E_ASSERT_NEXT(a_no_early_pad, clk_i, rst_ni, load && (idx_q < 2'd2), out_char_q != PadChar)
  `B64E_ASSERT_IMPL(a_pop_when_free, clk_i, rst_ni, pop && busy_q, load && (idx_q == LastIdx))
endmodule

FILE: tb/sv/tb_base64_stream_encoder.sv
// Self-checking testbench for the base64 stream encoder: drives message bytes with random
// gaps and stalls, predicts every character and compares each output request in order.
// Depends on b64e_pkg, b64e_byte_if, b64e_char_if and base64_stream_encoder.
module tb_base64_stream_encoder;
  import b64e_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int LongHold   = 400;
  localparam int DrainWait  = 16;
  localparam int RandomBytes = 450;
  localparam logic [511:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } b64_char_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eom;
    logic        known;
    logic [31:0] quad;
  } msg_byte_t;

  localparam int NumDirected = 21;
  msg_byte_t directed_bytes [NumDirected] = '{
    '{8'h00, 1'b1, 1'b1, "AA=="},
    '{8'hFF, 1'b1, 1'b1, "/w=="},
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b1, 1'b1, "AAA="},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b1, 1'b1, "//8="},
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b1, "AAAA"},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b1, 1'b1, "////"},
    '{8'h4D, 1'b0, 1'b0, 32'h0},
    '{8'h61, 1'b0, 1'b0, 32'h0},
    '{8'h6E, 1'b0, 1'b1, "TWFu"},
    '{8'h4D, 1'b1, 1'b1, "TQ=="},
    '{8'hAA, 1'b0, 1'b0, 32'h0},
    '{8'h55, 1'b1, 1'b0, 32'h0},
    '{8'h55, 1'b0, 1'b0, 32'h0},
    '{8'hAA, 1'b0, 1'b0, 32'h0},
    '{8'h01, 1'b1, 1'b0, 32'h0}
  };

  logic clk;
  logic rst_n;

  b64e_byte_if byte_ch ();
  b64e_char_if char_ch ();

  base64_stream_encoder dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (byte_ch),
    .out_o (char_ch)
  );

  b64_char_t   expected_chars [$];
  logic [7:0]  held_bytes [2];
  int unsigned held_count;
  int          mismatches;
  int          hold_requests;
  int          holds_served;
  bit          tx_quiet;
  bit          rx_quiet;

  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 19) == 0) begin
      quiet = !quiet;
    end
    return quiet ? 0 : int'($urandom_range(0, 16));
  endfunction

  function automatic logic [7:0] b64_letter(input logic [5:0] v);
    return Alphabet[{~v, 3'b000} +: 8];
  endfunction

  // Returns 1 when the byte closes a group, with the four characters in quad.
  function automatic bit encode_byte(input logic [7:0] data, input logic eom,
                                     output logic [31:0] quad);
    logic [7:0] a;
    logic [7:0] m;
    logic [7:0] c;
    int unsigned n;
    quad = '0;
    if (!eom && held_count < 2) begin
      held_bytes[held_count[0]] = data;
      held_count++;
      return 1'b0;
    end
    n = held_count + 1;
    a = (held_count >= 1) ? held_bytes[0] : data;
    m = (held_count >= 2) ? held_bytes[1] : ((held_count == 1) ? data : 8'h00);
    c = (held_count == 2) ? data : 8'h00;
    quad = {b64_letter(a[7:2]), b64_letter({a[1:0], m[7:4]}),
            b64_letter({m[3:0], c[7:6]}), b64_letter(c[5:0])};
    if (n < 3) begin
      quad[7:0] = {1'b0, PadChar};
    end
    if (n < 2) begin
      quad[15:8] = {1'b0, PadChar};
    end
    held_count = 0;
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input string what, input b64_char_t want,
                                        input b64_char_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected char %h last %b, got char %h last %b",
               what, want.ch, want.last, got.ch, got.last);
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic push_byte(input logic [7:0] data, input logic eom,
                           input logic known, input logic [31:0] known_quad);
    int gap;
    logic [31:0] quad;
    logic [7:0] ch8;
    gap = draw_wait(tx_quiet);
    if (gap > 0) begin
      byte_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid          = 1'b1;
    byte_ch.data_byte      = data;
    byte_ch.end_of_message = eom;
    do @(posedge clk); while (!byte_ch.ready);
    if (encode_byte(data, eom, quad)) begin
      if (known) begin
        quad = known_quad;
      end
      for (int k = 0; k < 4; k++) begin
        ch8 = quad[31:24];
        expected_chars.push_back('{ch: ch8[6:0], last: eom && (k == 3)});
        quad = {quad[23:0], 8'h00};
      end
    end
    @(negedge clk);
  endtask

  task automatic push_message(input int len);
    for (int i = 0; i < len; i++) begin
      push_byte(8'($urandom_range(0, 255)), i == len - 1, 1'b0, 32'h0);
    end
  endtask

  task automatic pause_until_drained();
    byte_ch.valid = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : receiver
    int stall;
    b64_char_t got;
    b64_char_t want;
    stall = 0;
    char_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        stall = LongHold;
        holds_served++;
      end
      char_ch.ready = (stall == 0);
      if (stall > 0) begin
        stall--;
      end
      @(posedge clk);
      if (char_ch.valid && char_ch.ready) begin
        got = '{ch: char_ch.out_char, last: char_ch.out_last};
        if (expected_chars.size() == 0) begin
          note_mismatch("unexpected", '0, got);
        end else begin
          want = expected_chars.pop_front();
          if (want.ch !== got.ch || want.last !== got.last) begin
            note_mismatch("wrong field", want, got);
          end
        end
        stall = draw_wait(rx_quiet);
      end
    end
  end

  initial begin : stimulus
    int sent;
    int len;
    int messages;
    rst_n                  = 1'b0;
    byte_ch.valid          = 1'b0;
    byte_ch.data_byte      = 8'h00;
    byte_ch.end_of_message = 1'b0;
    held_count             = 0;
    mismatches             = 0;
    hold_requests          = 0;
    holds_served           = 0;
    tx_quiet               = 1'b0;
    rx_quiet               = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_bytes[i]) begin
      push_byte(directed_bytes[i].data, directed_bytes[i].eom,
                directed_bytes[i].known, directed_bytes[i].quad);
    end
    pause_until_drained();

    // The receiver holds off while a long message keeps the input busy.
    hold_requests++;
    tx_quiet = 1'b1;
    push_message(30);
    pause_until_drained();

    sent = NumDirected + 30;
    messages = 0;
    while (sent < RandomBytes) begin
      len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(13, 40))
                                        : int'($urandom_range(1, 12));
      push_message(len);
      sent += len;
      messages++;
      if (messages % 8 == 0) begin
        pause_until_drained();
      end
    end

    byte_ch.valid = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
